/* hdl/mvw_pkg.sv */
package mvw_pkg;

  localparam int unsigned COORD_W = 24;
  localparam int unsigned IDX_W   = 13;
  localparam int unsigned TOL_W   = 52;
  localparam int unsigned SQ_W    = 50;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    OP_BEGIN = 2'd0,
    OP_NODE  = 2'd1,
    OP_FACE  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_UNMAPPED = 2'd2,
    STATUS_RSVD     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WELD_ENABLE  = 1'b0,
    CFG_TOLERANCE_SQ = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_FACE_RD,
    ST_FACE_WB,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]                op;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic [IDX_W-1:0]          face_ref;
  } in_t;

  typedef struct packed {
    logic [IDX_W-1:0] merged_index;
    logic             is_duplicate;
    logic [1:0]       status;
  } out_t;

  typedef struct packed {
    logic capture;
    logic begin_surf;
    logic zero_res;
    logic scan_start;
    logic commit;
    logic face_rd;
    logic face_wb;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

/* hdl/mvw_ctrl.sv */
module mvw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [1:0]        in_op_i,
  input  mvw_pkg::sts_t     sts_i,
  output logic              in_stall_o,
  output mvw_pkg::cmd_t     cmd_o
);

  mvw_pkg::state_e state_q, state_d;
  logic accept;

  assign in_stall_o = (state_q != mvw_pkg::ST_IDLE);
  assign accept     = in_valid_i && (state_q == mvw_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mvw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      mvw_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (mvw_pkg::op_e'(in_op_i))
            mvw_pkg::OP_NODE: state_d = mvw_pkg::ST_SCAN;
            mvw_pkg::OP_FACE: state_d = mvw_pkg::ST_FACE_RD;
            default:          state_d = mvw_pkg::ST_DONE;
          endcase
        end
      end
      mvw_pkg::ST_SCAN:    if (sts_i.scan_done) state_d = mvw_pkg::ST_COMMIT;
      mvw_pkg::ST_COMMIT:  state_d = mvw_pkg::ST_DONE;
      mvw_pkg::ST_FACE_RD: state_d = mvw_pkg::ST_FACE_WB;
      mvw_pkg::ST_FACE_WB: state_d = mvw_pkg::ST_DONE;
      mvw_pkg::ST_DONE:    if (sts_i.out_free) state_d = mvw_pkg::ST_IDLE;
      default:             state_d = mvw_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      mvw_pkg::ST_IDLE: begin
        cmd_o.capture    = accept;
        cmd_o.begin_surf = accept && (in_op_i == mvw_pkg::OP_BEGIN);
        cmd_o.scan_start = accept && (in_op_i == mvw_pkg::OP_NODE);
        cmd_o.zero_res   = accept && (in_op_i == mvw_pkg::OP_NONE);
      end
      mvw_pkg::ST_SCAN:    ;
      mvw_pkg::ST_COMMIT:  cmd_o.commit   = 1'b1;
      mvw_pkg::ST_FACE_RD: cmd_o.face_rd  = 1'b1;
      mvw_pkg::ST_FACE_WB: cmd_o.face_wb  = 1'b1;
      mvw_pkg::ST_DONE:    cmd_o.out_load = sts_i.out_free;
      default:             ;
    endcase
  end

endmodule

/* hdl/mvw_datapath.sv */
module mvw_datapath #(
  parameter int unsigned MAX_NODES = 4096,
  parameter int unsigned DIMS      = 3,
  parameter int unsigned IW        = 12,
  parameter int unsigned CW        = 13
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mvw_pkg::in_t                      in_data_i,
  input  mvw_pkg::cmd_t                     cmd_i,
  output mvw_pkg::sts_t                     sts_o,
  input  logic                              cfg_valid_i,
  input  logic [mvw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mvw_pkg::TOL_W-1:0]         cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output mvw_pkg::out_t                     out_data_o
);

  localparam int unsigned CDW = mvw_pkg::COORD_W;
  localparam int unsigned XW  = CW + mvw_pkg::IDX_W;
  localparam int unsigned WW  = DIMS * CDW;

  // configuration
  logic                      weld_q;
  logic [mvw_pkg::TOL_W-1:0] tol_q;

  // counters
  logic [CW-1:0] stored_q, prior_q, surface_q;

  // captured item
  logic signed [CDW-1:0]     coord_q [DIMS];
  logic signed [CDW-1:0]     in_coord [3];
  logic [mvw_pkg::IDX_W-1:0] face_ref_q;

  // memories
  logic [WW-1:0] store_mem [MAX_NODES];
  logic [WW-1:0] store_rd_q;
  logic [IW:0]   map_mem [MAX_NODES];
  logic [IW:0]   map_rd_q;

  // scan pipeline
  logic          issuing_q, v1_q, v2_q, found_q;
  logic [IW-1:0] ptr_q, idx1_q, idx2_q, hit_idx_q;
  logic [mvw_pkg::SQ_W-1:0] sq_q [DIMS];
  logic signed [2*CDW+1:0]  prod [DIMS];
  logic [mvw_pkg::TOL_W-1:0] dist_sq;
  logic hit_now, last_issue;

  // result
  mvw_pkg::out_t res_q, out_q;
  logic          out_valid_q;

  assign in_coord[0] = in_data_i.coord_x;
  assign in_coord[1] = in_data_i.coord_y;
  assign in_coord[2] = in_data_i.coord_z;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weld_q <= 1'b0;
      tol_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (mvw_pkg::cfg_idx_e'(cfg_index_i))
        mvw_pkg::CFG_WELD_ENABLE:  weld_q <= cfg_data_i[0];
        mvw_pkg::CFG_TOLERANCE_SQ: tol_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      for (int d = 0; d < DIMS; d++) coord_q[d] <= in_coord[d];
      face_ref_q <= in_data_i.face_ref;
    end
  end

  // distance stage: squares from the registered store word
  always_comb begin
    for (int d = 0; d < DIMS; d++) begin
      prod[d] = ($signed({coord_q[d][CDW-1], coord_q[d]})
                 - $signed({store_rd_q[d*CDW+CDW-1], store_rd_q[d*CDW +: CDW]}))
              * ($signed({coord_q[d][CDW-1], coord_q[d]})
                 - $signed({store_rd_q[d*CDW+CDW-1], store_rd_q[d*CDW +: CDW]}));
    end
  end

  always_ff @(posedge clk_i) begin
    for (int d = 0; d < DIMS; d++) sq_q[d] <= prod[d][mvw_pkg::SQ_W-1:0];
    idx1_q <= ptr_q;
    idx2_q <= idx1_q;
  end

  always_comb begin
    dist_sq = '0;
    for (int d = 0; d < DIMS; d++) begin
      dist_sq = dist_sq + {{(mvw_pkg::TOL_W - mvw_pkg::SQ_W){1'b0}}, sq_q[d]};
    end
  end

  assign hit_now    = v2_q && (dist_sq <= tol_q);
  assign last_issue = ({{(CW + 1 - IW){1'b0}}, ptr_q} + (CW + 1)'(1)) == {1'b0, prior_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issuing_q <= 1'b0;
      v1_q      <= 1'b0;
      v2_q      <= 1'b0;
      found_q   <= 1'b0;
      ptr_q     <= '0;
      hit_idx_q <= '0;
    end else begin
      v1_q <= issuing_q;
      v2_q <= v1_q;
      if (cmd_i.scan_start) begin
        ptr_q     <= '0;
        found_q   <= 1'b0;
        issuing_q <= weld_q && (prior_q != '0);
      end else if (issuing_q) begin
        ptr_q <= ptr_q + IW'(1);
        if (last_issue) issuing_q <= 1'b0;
      end
      // first match wins; later in-flight compares are dropped
      if (hit_now) begin
        found_q   <= 1'b1;
        hit_idx_q <= idx2_q;
        issuing_q <= 1'b0;
        v1_q      <= 1'b0;
        v2_q      <= 1'b0;
      end
    end
  end

  assign sts_o.scan_done = !issuing_q && !v1_q && !v2_q;

  // commit of a node
  logic          store_full, surf_full, commit_mapped, store_wr;
  logic [IW-1:0] commit_idx;
  logic [XW-1:0] commit_idx_x, stored_x;

  assign store_full   = (stored_q == CW'(MAX_NODES));
  assign surf_full    = (surface_q == CW'(MAX_NODES));
  assign store_wr     = cmd_i.commit && !found_q && !store_full;
  assign commit_mapped = found_q || !store_full;
  assign commit_idx   = found_q ? hit_idx_q : stored_q[IW-1:0];
  assign commit_idx_x = {{(XW - IW){1'b0}}, commit_idx};
  assign stored_x     = {{(XW - CW){1'b0}}, stored_q};

  always_ff @(posedge clk_i) begin
    if (store_wr) begin
      for (int d = 0; d < DIMS; d++) store_mem[stored_q[IW-1:0]][d*CDW +: CDW] <= coord_q[d];
    end
    store_rd_q <= store_mem[ptr_q];
  end

  // face lookup
  logic [XW-1:0] ref_x, surf_x, map_idx_x;
  logic [IW-1:0] map_addr;
  logic          face_ok;

  assign ref_x     = {{(XW - mvw_pkg::IDX_W){1'b0}}, face_ref_q};
  assign surf_x    = {{(XW - CW){1'b0}}, surface_q};
  assign map_addr  = IW'(ref_x - XW'(1));
  assign map_idx_x = {{(XW - IW){1'b0}}, map_rd_q[IW-1:0]} + XW'(1);
  assign face_ok   = (ref_x != '0) && (ref_x <= surf_x) && map_rd_q[IW];

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && !surf_full) begin
      map_mem[surface_q[IW-1:0]] <= {commit_mapped, commit_idx};
    end
    if (cmd_i.face_rd) map_rd_q <= map_mem[map_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q  <= '0;
      prior_q   <= '0;
      surface_q <= '0;
    end else begin
      if (cmd_i.begin_surf) begin
        prior_q   <= stored_q;
        surface_q <= '0;
      end
      if (store_wr) stored_q <= stored_q + CW'(1);
      if (cmd_i.commit && !surf_full) surface_q <= surface_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.begin_surf) begin
      res_q.merged_index <= stored_x[mvw_pkg::IDX_W-1:0];
      res_q.is_duplicate <= 1'b0;
      res_q.status       <= mvw_pkg::STATUS_OK;
    end else if (cmd_i.zero_res) begin
      res_q <= '0;
    end else if (cmd_i.commit) begin
      res_q.merged_index <= commit_mapped ? commit_idx_x[mvw_pkg::IDX_W-1:0] : '0;
      res_q.is_duplicate <= found_q;
      res_q.status       <= commit_mapped ? mvw_pkg::STATUS_OK : mvw_pkg::STATUS_FULL;
    end else if (cmd_i.face_wb) begin
      res_q.merged_index <= face_ok ? map_idx_x[mvw_pkg::IDX_W-1:0] : '0;
      res_q.is_duplicate <= 1'b0;
      res_q.status       <= face_ok ? mvw_pkg::STATUS_OK : mvw_pkg::STATUS_UNMAPPED;
    end
  end

  // output register
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) out_q <= res_q;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CW'(MAX_NODES)) else $error("node store count overflow");
  a_prior_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prior_q <= stored_q) else $error("prior count exceeds store count");
  a_hit_prior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hit_now |-> ({{(CW - IW){1'b0}}, idx2_q} < prior_q))
    else $error("weld hit outside prior nodes");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.out_load |-> (!out_valid_q || !out_stall_i))
    else $error("result overwritten before transaction");
`endif

endmodule

/* hdl/mesh_vertex_weld_merge.sv */
// Sequence: node items with welding on scan the node store, one store compare
//   per cycle over the nodes stored before the current surface, stopping at
//   the first match, then commit; with welding off or no prior nodes the scan
//   is skipped. Face items read the index map, then write the result back.
// Throughput: one item at a time; input stalls until the result is loaded.
// Reset: asynchronous active low; clears counters, configuration and control.
//   Node store and index map are not cleared; no clearing pass.
module mesh_vertex_weld_merge #(
  parameter int unsigned MAX_NODES = 4096,
  parameter int unsigned DIMS      = 3
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  mvw_pkg::in_t                  in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output mvw_pkg::out_t                 out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mvw_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [mvw_pkg::TOL_W-1:0]     cfg_data_i
);

  localparam int unsigned IW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  mvw_pkg::cmd_t cmd;
  mvw_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  mvw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  mvw_datapath #(
    .MAX_NODES (MAX_NODES),
    .DIMS      (DIMS),
    .IW        (IW),
    .CW        (CW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
